>>> src/wua_pkg.sv
// Package: shared types and constants for the wide unsigned ALU.
`timescale 1ns / 1ps
package wua_pkg;

  localparam int unsigned WordBitsDefault = 128;
  localparam int unsigned HalfBits        = 64;
  localparam int unsigned OpBits          = 3;
  localparam int unsigned ErrBits         = 2;

  typedef enum logic [OpBits-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_REM = 3'd4
  } op_e;

  typedef enum logic [ErrBits-1:0] {
    ERR_NONE  = 2'd0,
    ERR_OVER  = 2'd1,
    ERR_UNDER = 2'd2,
    ERR_DIVZ  = 2'd3
  } err_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture operands, clear accumulators
    logic mul_step;  // one shift-add multiply step
    logic div_step;  // one restoring division step
    logic finish;    // form result into output register
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_iter;   // captured operation needs the bit loop
  } dp_status_t;

endpackage

>>> src/wua_if.sv
// Interfaces: valid/ready channels for operands and results.
`timescale 1ns / 1ps
interface wua_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        operation;
  logic [63:0]       a_lo;
  logic [63:0]       a_hi;
  logic [63:0]       b_lo;
  logic [63:0]       b_hi;
  modport source (output valid, operation, a_lo, a_hi, b_lo, b_hi, input ready);
  modport sink   (input valid, operation, a_lo, a_hi, b_lo, b_hi, output ready);
endinterface

interface wua_out_if;
  logic              valid;
  logic              ready;
  logic [63:0]       result_lo;
  logic [63:0]       result_hi;
  logic [1:0]        error_code;
  logic              a_less_than_b;
  logic              a_equals_b;
  modport source (output valid, result_lo, result_hi, error_code, a_less_than_b,
                  a_equals_b, input ready);
  modport sink   (input valid, result_lo, result_hi, error_code, a_less_than_b,
                  a_equals_b, output ready);
endinterface

>>> src/wide_unsigned_alu_128_top.sv
// Top level: 128-bit unsigned ALU with add, subtract, multiply, divide, remainder.
`timescale 1ns / 1ps
//  channel | dir | payload                                           | accepted when
//  in_if   | in  | operation, a_lo, a_hi, b_lo, b_hi                 | valid & ready
//  out_if  | out | result_lo, result_hi, error_code, a_less_than_b,  | valid & ready
//          |     | a_equals_b                                        |
//
// One transaction at a time. Add, subtract and unknown codes go from load through the
// finish step to the output register; multiply, divide and remainder first run the
// one-bit-per-cycle shift-add / restoring loop over all WordBits bits.
// A result waits in the output register until taken; the input is held off
// until then. Reset clears the controller and the compare flags only.
module wide_unsigned_alu_128_top #(
  parameter int unsigned WordBits = wua_pkg::WordBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wua_in_if.sink     in_if,
  wua_out_if.source  out_if
);
  import wua_pkg::*;

  dp_cmd_t      cmd;
  dp_status_t   status;
  logic         is_mul;
  logic [127:0] result;

  wua_ctrl #(.WordBits(WordBits)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .status_i    (status),
    .is_mul_i    (is_mul),
    .cmd_o       (cmd)
  );

  // Hand the full operands down; the datapath masks to the word.
  wua_dp #(.WordBits(WordBits)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .operation_i  (in_if.operation),
    .a_i          ({in_if.a_hi, in_if.a_lo}),
    .b_i          ({in_if.b_hi, in_if.b_lo}),
    .status_o     (status),
    .is_mul_o     (is_mul),
    .result_o     (result),
    .error_code_o (out_if.error_code),
    .lt_o         (out_if.a_less_than_b),
    .eq_o         (out_if.a_equals_b)
  );

  assign out_if.result_lo = result[63:0];
  assign out_if.result_hi = result[127:64];

endmodule

>>> src/wua_ctrl.sv
// Controller: sequences load, bit iterations and result hand-off.
`timescale 1ns / 1ps
module wua_ctrl #(
  parameter int unsigned WordBits = wua_pkg::WordBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  wua_pkg::dp_status_t  status_i,
  input  logic                 is_mul_i,
  output wua_pkg::dp_cmd_t     cmd_o
);
  import wua_pkg::*;

  localparam int unsigned CntBits = $clog2(WordBits);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_FIN  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [CntBits-1:0] cnt_q, cnt_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!status_i.is_iter) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.mul_step = is_mul_i;
          cmd_o.div_step = !is_mul_i;
          cnt_d          = cnt_q + 1'b1;
          if (cnt_q == CntBits'(WordBits - 1)) state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

>>> src/wua_dp.sv
// Datapath: operand registers, shift-add multiplier, restoring divider.
`timescale 1ns / 1ps
module wua_dp #(
  parameter int unsigned WordBits = wua_pkg::WordBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wua_pkg::dp_cmd_t     cmd_i,
  input  logic [2:0]           operation_i,
  input  logic [127:0]         a_i,
  input  logic [127:0]         b_i,
  output wua_pkg::dp_status_t  status_o,
  output logic                 is_mul_o,
  output logic [127:0]         result_o,
  output logic [1:0]           error_code_o,
  output logic                 lt_o,
  output logic                 eq_o
);
  import wua_pkg::*;

  localparam int unsigned W = WordBits;

  logic [2:0]   op_q;
  logic [W-1:0] a_q, b_q;   // a_q doubles as multiplier / dividend shifter
  logic [W-1:0] acc_q;      // product low or remainder
  logic [W-1:0] qt_q;       // quotient bits
  logic         ovf_q;      // multiply overflow so far
  logic [W-1:0] bm_q;       // shifted multiplicand for multiply
  logic         bm_hi_q;    // multiplicand has been shifted past the word
  logic [127:0] res_q;
  logic [1:0]   err_q;
  logic         lt_q, eq_q;

  // Mul step: add shifted multiplicand when multiplier bit set.
  logic [W:0]   mul_sum;
  logic         mul_bit;
  // Div step: shift in dividend MSB, compare, subtract.
  logic [W:0]   div_r;
  logic [W:0]   div_diff;
  logic         div_ge;
  // Add/sub on captured operands.
  logic [W:0]   add_sum;
  logic         a_lt_b;

  assign mul_bit  = a_q[0];
  assign mul_sum  = {1'b0, acc_q} + {1'b0, bm_q};
  assign div_r    = {acc_q, a_q[W-1]};
  assign div_diff = div_r - {1'b0, b_q};
  assign div_ge   = !div_diff[W];
  assign add_sum  = {1'b0, a_q} + {1'b0, b_q};
  assign a_lt_b   = (a_q < b_q);

  assign status_o.is_iter = (op_q == OP_MUL) || (op_q == OP_DIV) || (op_q == OP_REM);
  assign is_mul_o = (op_q == OP_MUL);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= operation_i;
      a_q     <= a_i[W-1:0];
      b_q     <= b_i[W-1:0];
      bm_q    <= b_i[W-1:0];
      bm_hi_q <= 1'b0;
      acc_q   <= '0;
      qt_q    <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.mul_step) begin
      if (mul_bit) begin
        acc_q <= mul_sum[W-1:0];
        if (mul_sum[W] || bm_hi_q) ovf_q <= 1'b1;
      end
      // Shift multiplicand up; any bit leaving the word makes later adds overflow.
      bm_q    <= {bm_q[W-2:0], 1'b0};
      bm_hi_q <= bm_hi_q | bm_q[W-1];
      a_q     <= {1'b0, a_q[W-1:1]};
    end else if (cmd_i.div_step) begin
      a_q  <= {a_q[W-2:0], 1'b0};
      qt_q <= {qt_q[W-2:0], div_ge};
      acc_q <= div_ge ? div_diff[W-1:0] : div_r[W-1:0];
    end
  end

  // Multiplier in a_q shifts out during multiply, so compare flags are
  // captured at load from the input side.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else if (cmd_i.load) begin
      lt_q <= (a_i[W-1:0] < b_i[W-1:0]);
      eq_q <= (a_i[W-1:0] == b_i[W-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_q <= '0;
      err_q <= ERR_NONE;
      unique case (op_q)
        OP_ADD: begin
          if (add_sum[W]) err_q <= ERR_OVER;
          else res_q <= 128'(add_sum[W-1:0]);
        end
        OP_SUB: begin
          if (a_lt_b) err_q <= ERR_UNDER;
          else res_q <= 128'(a_q - b_q);
        end
        OP_MUL: begin
          if (ovf_q) err_q <= ERR_OVER;
          else res_q <= 128'(acc_q);
        end
        OP_DIV: begin
          if (b_q == '0) err_q <= ERR_DIVZ;
          else res_q <= 128'(qt_q);
        end
        OP_REM: begin
          if (b_q == '0) err_q <= ERR_DIVZ;
          else res_q <= 128'(acc_q);
        end
        default: ;
      endcase
    end
  end

  assign result_o     = res_q;
  assign error_code_o = err_q;
  assign lt_o         = lt_q;
  assign eq_o         = eq_q;

endmodule
